// File: rtl/core/varint_length_prefix_deframer_unit_macros.svh
// Assertion macros for the varint length-prefix deframer.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef VARINT_LENGTH_PREFIX_DEFRAMER_UNIT_MACROS_SVH
`define VARINT_LENGTH_PREFIX_DEFRAMER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define VLPD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition never holds at a clock edge outside reset.
`define VLPD_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VLPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define VLPD_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/core/vlpd_pkg.sv
// Shared types and constants of the varint length-prefix deframer.
// Used by every module of the block; depends on nothing.
`default_nettype none
package vlpd_pkg;

	localparam int unsigned GROUP_W    = 7;
	localparam int unsigned CONT_BIT   = 7;
	localparam logic [2:0]  LAST_GROUP = 3'd4;
	localparam int unsigned TDATA_W    = 48;
	localparam int unsigned TUSER_W    = 2;

	typedef enum logic [1:0] {
		PH_LENGTH  = 2'd0,
		PH_ID      = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CLOSED  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_ZERO_LEN  = 3'd1,
		ERR_LEN_LONG  = 3'd2,
		ERR_ID_LONG   = 3'd3,
		ERR_ID_TRUNC  = 3'd4
	} err_t;

	typedef struct packed {
		kind_t              kind;
		err_t               err_code;
		logic signed [31:0] packet_id;
		logic [7:0]         payload_byte;
		logic               frame_end;
	} rec_t;

	// Place a 7-bit varint group at its bit position; upper bits of group 4 fall off.
	function automatic logic [31:0] vlpd_group(input logic [6:0] g, input logic [2:0] idx);
		logic [31:0] r;
		case (idx)
			3'd0: r = {25'd0, g};
			3'd1: r = {18'd0, g, 7'd0};
			3'd2: r = {11'd0, g, 14'd0};
			3'd3: r = {4'd0, g, 21'd0};
			3'd4: r = {g[3:0], 28'd0};
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/varint_length_prefix_deframer_unit.sv
// A result enters the queue when its byte is taken, then the output register drives m_axis.
// Throughput: one byte per clock while the queue has room (one varint or payload step each).
// Back-pressure is absorbed by a QUEUE_DEPTH-entry queue plus the output register.
// Reset: arst_n clears the parser to the length phase, empties the queue, drops m_axis_tvalid.
// After a protocol error the block keeps taking bytes and drops them until reset.
// Top level of the varint length-prefix deframer; depends on vlpd_pkg and the vlpd_* modules.
`default_nettype none
module varint_length_prefix_deframer_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// slave stream: tdata[7:0] = data_byte
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [7:0]                     s_axis_tdata,
	// master stream: tdata[2:0] = err_code, [34:3] = packet_id,
	// [42:35] = payload_byte, [47:43] = zero fill
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [vlpd_pkg::TDATA_W-1:0]        m_axis_tdata,
	// tuser[1:0] = kind
	output logic [vlpd_pkg::TUSER_W-1:0]        m_axis_tuser,
	// tlast = frame_end
	output logic                                m_axis_tlast
);
	import vlpd_pkg::*;

	logic push, pop, q_not_full, q_not_empty;
	rec_t push_rec, head;

	// Front: take one byte per beat while the queue has room, classify it, push any result.
	vlpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_data  (s_axis_tdata),
		.space    (q_not_full),
		.in_ready (s_axis_tready),
		.push     (push),
		.push_rec (push_rec)
	);

	// Queue: decouple parsing from output back-pressure.
	vlpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.not_full  (q_not_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	// Back: hold each result in the output register until the master side takes it.
	vlpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_not_empty),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// File: rtl/core/vlpd_front.sv
// Front parser: decodes length and id varints, classifies each byte, pushes results.
// Depends on vlpd_pkg and the assertion macro header.
`default_nettype none
`include "varint_length_prefix_deframer_unit_macros.svh"
module vlpd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [7:0]    in_data,
	input  wire logic          space,
	output logic               in_ready,
	output logic               push,
	output vlpd_pkg::rec_t     push_rec
);
	import vlpd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] len_q, rem_q, id_q;
	logic [2:0]  len_cnt_q, id_cnt_q;

	logic        accept, cont, len_last, id_last, rem_zero, len_is_zero;
	logic [31:0] len_new, id_new, rem_dec;

	assign in_ready    = space;
	assign accept      = in_valid && space;
	assign cont        = in_data[CONT_BIT];
	assign len_new     = len_q | vlpd_group(in_data[GROUP_W-1:0], len_cnt_q);
	assign id_new      = id_q | vlpd_group(in_data[GROUP_W-1:0], id_cnt_q);
	assign rem_dec     = rem_q - 32'd1;
	assign rem_zero    = (rem_dec == 32'd0);
	assign len_is_zero = (len_new == 32'd0);
	assign len_last    = (len_cnt_q == LAST_GROUP);
	assign id_last     = (id_cnt_q == LAST_GROUP);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			case (phase_q)
				PH_LENGTH: begin
					if (!cont) phase_d = len_is_zero ? PH_CLOSED : PH_ID;
					else if (len_last) phase_d = PH_CLOSED;
				end
				PH_ID: begin
					if (!cont) phase_d = rem_zero ? PH_LENGTH : PH_PAYLOAD;
					else if (id_last || rem_zero) phase_d = PH_CLOSED;
				end
				PH_PAYLOAD: begin
					if (rem_zero) phase_d = PH_LENGTH;
				end
				default: phase_d = PH_CLOSED;
			endcase
		end
	end

	// result for the byte taken this cycle
	always_comb begin
		push     = 1'b0;
		push_rec = '{kind: KIND_ERROR, err_code: ERR_NONE, packet_id: 32'sd0,
			payload_byte: 8'd0, frame_end: 1'b1};
		if (accept) begin
			case (phase_q)
				PH_LENGTH: begin
					if (!cont && len_is_zero) begin
						push              = 1'b1;
						push_rec.err_code = ERR_ZERO_LEN;
					end else if (cont && len_last) begin
						push              = 1'b1;
						push_rec.err_code = ERR_LEN_LONG;
					end
				end
				PH_ID: begin
					if (!cont) begin
						if (rem_zero) begin
							push               = 1'b1;
							push_rec.kind      = KIND_EMPTY;
							push_rec.packet_id = id_new;
						end
					end else if (id_last) begin
						push              = 1'b1;
						push_rec.err_code = ERR_ID_LONG;
					end else if (rem_zero) begin
						push              = 1'b1;
						push_rec.err_code = ERR_ID_TRUNC;
					end
				end
				PH_PAYLOAD: begin
					push                  = 1'b1;
					push_rec.kind         = KIND_PAYLOAD;
					push_rec.packet_id    = id_q;
					push_rec.payload_byte = in_data;
					push_rec.frame_end    = rem_zero;
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LENGTH;
			len_q     <= 32'd0;
			len_cnt_q <= 3'd0;
			rem_q     <= 32'd0;
			id_q      <= 32'd0;
			id_cnt_q  <= 3'd0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				case (phase_q)
					PH_LENGTH: begin
						if (cont) begin
							len_q     <= len_new;
							len_cnt_q <= len_cnt_q + 3'd1;
						end else begin
							len_q     <= 32'd0;
							len_cnt_q <= 3'd0;
							rem_q     <= len_new;
							id_q      <= 32'd0;
							id_cnt_q  <= 3'd0;
						end
					end
					PH_ID: begin
						rem_q <= rem_dec;
						id_q  <= id_new;
						if (cont) id_cnt_q <= id_cnt_q + 3'd1;
					end
					PH_PAYLOAD: rem_q <= rem_dec;
					default: rem_q <= rem_q;
				endcase
			end
		end
	end

	`VLPD_ASSERT(a_closed_sticks, clk, arst_n, (phase_q == PH_CLOSED) |=> (phase_q == PH_CLOSED), "closed phase left before reset")
	`VLPD_ASSERT(a_error_closes, clk, arst_n, (push && push_rec.kind == KIND_ERROR) |=> (phase_q == PH_CLOSED), "error result without closing")
	`VLPD_NEVER(a_no_push_closed, clk, arst_n, (phase_q == PH_CLOSED) && push, "result pushed while closed")

endmodule
`default_nettype wire

// File: rtl/core/vlpd_queue.sv
// Short result queue between the front parser and the output stage.
// Depends on vlpd_pkg and the assertion macro header.
`default_nettype none
`include "varint_length_prefix_deframer_unit_macros.svh"
module vlpd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire vlpd_pkg::rec_t push_rec,
	input  wire logic           pop,
	output logic                not_full,
	output logic                not_empty,
	output vlpd_pkg::rec_t      head
);
	import vlpd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	rec_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign not_full  = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`VLPD_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count above depth")
	`VLPD_NEVER(a_push_full, clk, arst_n, push && !not_full, "push into full queue")
	`VLPD_NEVER(a_pop_empty, clk, arst_n, pop && !not_empty, "pop from empty queue")

endmodule
`default_nettype wire

// File: rtl/core/vlpd_back.sv
// Output stage: takes results from the queue into a register and drives the master stream.
// Depends on vlpd_pkg.
`default_nettype none
module vlpd_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           head_valid,
	input  wire vlpd_pkg::rec_t                 head,
	output logic                                pop,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [vlpd_pkg::TDATA_W-1:0]        m_axis_tdata,
	output logic [vlpd_pkg::TUSER_W-1:0]        m_axis_tuser,
	output logic                                m_axis_tlast
);
	import vlpd_pkg::*;

	logic valid_q;
	rec_t rec_q;

	// refill whenever the register is empty or its beat is taken now
	assign pop = head_valid && (!valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (!valid_q || m_axis_tready) valid_q <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (pop) rec_q <= head;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {5'd0, rec_q.payload_byte, rec_q.packet_id, rec_q.err_code};
	assign m_axis_tuser  = rec_q.kind;
	assign m_axis_tlast  = rec_q.frame_end;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for varint_length_prefix_deframer_unit: feeds framed byte streams,
// predicts every result beat and compares it. Depends on vlpd_pkg and the block's RTL.
module tb_top;
	import vlpd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SHIFT_LIMIT = 35;   // five groups of seven bits
	localparam int unsigned IDLE_PCT    = 16;
	localparam int unsigned ID_LSB      = 3;
	localparam int unsigned PAY_LSB     = 35;
	localparam int unsigned FILL_LSB    = 43;

	// One result beat as the deframer should produce it.
	typedef struct {
		kind_t              kind;
		err_t               code;
		logic signed [31:0] id;
		logic [7:0]         payload;
		logic               last;
	} deframed_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic [TUSER_W-1:0]  m_axis_tuser;
	logic                m_axis_tlast;

	// Shadow of the parser state.
	phase_t              rx_phase = PH_LENGTH;
	logic [31:0]         len_acc = '0;
	int unsigned         len_shift = 0;
	logic [31:0]         body_left = '0;
	logic [31:0]         id_acc = '0;
	int unsigned         id_shift = 0;

	deframed_t           deframed_q[$];
	bit                  no_idle = 1'b0;
	int unsigned         stall_req = 0;
	int unsigned         cycles = 0;
	int unsigned         mismatches = 0;
	int unsigned         stream_bytes = 0;
	int unsigned         frames_sent = 0;
	int unsigned         payload_beats = 0;
	int unsigned         empty_frames = 0;
	err_t                closing_code = ERR_NONE;

	varint_length_prefix_deframer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a correct run finishes far below this.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("varint_length_prefix_deframer_unit regression: fail");
			$finish;
		end
	end

	// Place one 7-bit group; anything shifted past bit 31 is lost.
	function automatic logic [31:0] place_group(input logic [7:0] b, input int unsigned sh);
		logic [31:0] g;
		g = {25'd0, b[GROUP_W-1:0]};
		return (sh >= 32) ? 32'd0 : (g << sh);
	endfunction

	// Append one predicted beat at the tail of the scoreboard.
	function automatic void predict_beat(input deframed_t d);
		deframed_q = {deframed_q, d};
	endfunction

	function automatic void close_stream(input err_t c);
		rx_phase = PH_CLOSED;
		predict_beat('{KIND_ERROR, c, 32'sd0, 8'd0, 1'b1});
	endfunction

	// Advance the shadow parser by one accepted byte and queue any result it yields.
	function automatic void deframe_byte(input logic [7:0] b);
		case (rx_phase)
			PH_LENGTH: begin
				len_acc |= place_group(b, len_shift);
				if (!b[CONT_BIT]) begin
					if (len_acc == 32'd0) begin
						close_stream(ERR_ZERO_LEN);
					end else begin
						body_left = len_acc;
						id_acc    = '0;
						id_shift  = 0;
						rx_phase  = PH_ID;
					end
					len_acc   = '0;
					len_shift = 0;
				end else begin
					len_shift += GROUP_W;
					if (len_shift >= SHIFT_LIMIT)
						close_stream(ERR_LEN_LONG);
				end
			end
			PH_ID: begin
				body_left -= 1;
				id_acc |= place_group(b, id_shift);
				if (!b[CONT_BIT]) begin
					if (body_left == 32'd0) begin
						rx_phase = PH_LENGTH;
						predict_beat('{KIND_EMPTY, ERR_NONE, id_acc, 8'd0, 1'b1});
					end else begin
						rx_phase = PH_PAYLOAD;
					end
				end else begin
					id_shift += GROUP_W;
					// overlong id wins over a body that ends mid-varint
					if (id_shift >= SHIFT_LIMIT)
						close_stream(ERR_ID_LONG);
					else if (body_left == 32'd0)
						close_stream(ERR_ID_TRUNC);
				end
			end
			PH_PAYLOAD: begin
				body_left -= 1;
				predict_beat('{KIND_PAYLOAD, ERR_NONE, id_acc, b, body_left == 32'd0});
				if (body_left == 32'd0)
					rx_phase = PH_LENGTH;
			end
			default: ;
		endcase
	endfunction

	function automatic int unsigned varint_bytes(input logic [31:0] v);
		int unsigned n;
		n = 1;
		while (n < 5 && (v >> (GROUP_W * n)) != 0)
			n++;
		return n;
	endfunction

	// Offer one beat, with a random gap first, and hold it until taken.
	task automatic send_byte(input logic [7:0] b);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (rx_phase != PH_CLOSED)
			stream_bytes++;
		deframe_byte(b);
	endtask

	// Emit v in nbytes groups; junk lands in the dropped top bits of a fifth group.
	// cont_last keeps the continue bit on the final byte too.
	task automatic send_varint(input logic [31:0] v, input int unsigned nbytes,
			input logic [2:0] junk, input bit cont_last);
		logic [7:0] b;
		for (int unsigned i = 0; i < nbytes; i++) begin
			if (i == 4)
				b[6:0] = {junk, v[31:28]};
			else
				b[6:0] = v[GROUP_W*i +: GROUP_W];
			b[CONT_BIT] = (i + 1 < nbytes) || cont_last;
			send_byte(b);
		end
	endtask

	// One well-formed frame; fill < 0 gives random payload bytes.
	task automatic send_frame(input logic [31:0] id, input int unsigned id_pad, input bit len_long,
			input int unsigned npay, input int fill, input logic [2:0] junk);
		int unsigned id_n;
		int unsigned body;
		id_n = varint_bytes(id) + id_pad;
		if (id_n > 5)
			id_n = 5;
		body = id_n + npay;
		send_varint(body, len_long ? 5 : varint_bytes(body), junk, 1'b0);
		send_varint(id, id_n, junk, 1'b0);
		for (int unsigned i = 0; i < npay; i++)
			send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
		frames_sent++;
	endtask

	// Field extremes, empty frames, extreme ids, and overflow bits in five-byte varints.
	task automatic test_directed_frames;
		send_frame(32'd0, 0, 1'b0, 1, 8'h00, 3'b000);
		send_frame(32'd127, 0, 1'b0, 1, 8'hFF, 3'b000);
		send_frame(32'h7FFF_FFFF, 0, 1'b0, 0, -1, 3'b000);
		send_frame(32'hFFFF_FFFF, 0, 1'b1, 1, 8'hA5, 3'b111);
		send_frame(32'h8000_0000, 0, 1'b0, 0, -1, 3'b101);
	endtask

	// Hold the result side off for a long stretch while a long frame keeps coming.
	task automatic test_back_pressure;
		no_idle   = 1'b1;
		stall_req = 64;
		send_frame($urandom, 0, 1'b0, 48, -1, 3'($urandom));
		no_idle   = 1'b0;
	endtask

	// Random well-formed frames, with one stretch at full rate on both sides.
	task automatic test_random_frames;
		int unsigned target;
		logic [31:0] id;
		int unsigned npay;
		target = stream_bytes + 400;
		while (stream_bytes < target) begin
			no_idle = (stream_bytes + 350 >= target) && (stream_bytes + 250 < target);
			case ($urandom_range(3))
				0: id = $urandom_range(127);
				1: id = $urandom_range(16383);
				2: id = $urandom;
				default: id = 32'd0 - $urandom_range(1, 1000);
			endcase
			npay = ($urandom_range(4) == 0) ? $urandom_range(7, 40) : $urandom_range(6);
			send_frame(id, ($urandom_range(9) == 0) ? $urandom_range(1, 4) : 0,
				$urandom_range(19) == 0, npay, -1, 3'($urandom));
		end
		no_idle = 1'b0;
	endtask

	// Only one protocol error per run: the stream stays closed afterwards. Pick it at random,
	// then push noise that must be swallowed without any result.
	task automatic test_protocol_error;
		err_t pick;
		int unsigned n;
		pick = err_t'($urandom_range(int'(ERR_ZERO_LEN), int'(ERR_ID_TRUNC)));
		case (pick)
			ERR_ZERO_LEN: send_varint(32'd0, $urandom_range(1, 5), 3'($urandom), 1'b0);
			ERR_LEN_LONG: send_varint($urandom, 5, 3'($urandom), 1'b1);
			ERR_ID_LONG: begin
				n = $urandom_range(5, 40);
				send_varint(n, varint_bytes(n), 3'b000, 1'b0);
				send_varint($urandom, 5, 3'($urandom), 1'b1);
			end
			default: begin
				n = $urandom_range(1, 4);
				send_varint(n, 1, 3'b000, 1'b0);
				send_varint($urandom, n, 3'b000, 1'b1);
			end
		endcase
		repeat (20)
			send_byte(8'($urandom));
	endtask

	// Result side ready: random drops, or a counted hold when one is requested.
	initial begin
		int unsigned hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (stall_req != 0) begin
				hold      = stall_req;
				stall_req = 0;
			end
			if (hold != 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Compare every result beat against the oldest prediction.
	always @(posedge clk) begin
		deframed_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (deframed_q.size() == 0) begin
				$error("unexpected result beat: tuser %0h tdata %0h tlast %0b",
					m_axis_tuser, m_axis_tdata, m_axis_tlast);
				mismatches++;
			end else begin
				want = deframed_q[0];
				deframed_q.delete(0);
				if (kind_t'(m_axis_tuser) != want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[ID_LSB-1:0] != want.code) begin
					$error("err_code: expected %0d, got %0d", want.code,
						m_axis_tdata[ID_LSB-1:0]);
					mismatches++;
				end
				if ($signed(m_axis_tdata[PAY_LSB-1:ID_LSB]) != want.id) begin
					$error("packet_id: expected %0d, got %0d", want.id,
						$signed(m_axis_tdata[PAY_LSB-1:ID_LSB]));
					mismatches++;
				end
				if (m_axis_tdata[FILL_LSB-1:PAY_LSB] != want.payload) begin
					$error("payload_byte: expected %0h, got %0h", want.payload,
						m_axis_tdata[FILL_LSB-1:PAY_LSB]);
					mismatches++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("frame_end: expected %0b, got %0b", want.last, m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tdata[TDATA_W-1:FILL_LSB] != '0) begin
					$error("tdata fill: expected 0, got %0h", m_axis_tdata[TDATA_W-1:FILL_LSB]);
					mismatches++;
				end
				case (want.kind)
					KIND_PAYLOAD: payload_beats++;
					KIND_EMPTY: empty_frames++;
					default: closing_code = want.code;
				endcase
			end
		end
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		arst_n        = 1'b0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_frames;
		test_back_pressure;
		test_random_frames;
		test_protocol_error;

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (deframed_q.size() != 0)
			@(posedge clk);
		// leave room for any stray beat
		repeat (20)
			@(posedge clk);

		$display("covered %0d stream bytes in %0d frames: %0d payload beats, %0d empty frames",
			stream_bytes, frames_sent, payload_beats, empty_frames);
		$display("stream closed by %s, then noise bytes dropped", closing_code.name());
		if (mismatches == 0)
			$display("varint_length_prefix_deframer_unit regression: pass");
		else
			$display("varint_length_prefix_deframer_unit regression: fail");
		$finish;
	end

endmodule
